[rtl/nprc_pkg.sv]
// Shared types and constants for the PRC sentence parser.
// No dependencies; imported by the front end, back end and top level.
`timescale 1ns / 1ps
`default_nettype none

package nprc_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam logic [2:0]  LETTER_BAD = 3'd7;
  localparam logic [2:0]  LEN_MAX    = 3'd7;
  localparam logic [2:0]  HDR_LEN    = 3'd6;
  localparam logic [13:0] NUM_MAX    = 14'd9999;
  localparam logic [7:0]  SHAFT_MAX  = 8'd255;

  // field indexes within a sentence
  localparam logic [3:0] FLD_HDR        = 4'd0;
  localparam logic [3:0] FLD_LEVER_POS  = 4'd1;
  localparam logic [3:0] FLD_LEVER_ST   = 4'd2;
  localparam logic [3:0] FLD_RPM        = 4'd3;
  localparam logic [3:0] FLD_RPM_MODE   = 4'd4;
  localparam logic [3:0] FLD_PITCH      = 4'd5;
  localparam logic [3:0] FLD_PITCH_MODE = 4'd6;
  localparam logic [3:0] FLD_LOC        = 4'd7;
  localparam logic [3:0] FLD_SHAFT      = 4'd8;

  localparam logic [3:0] ST_OK = 4'd0;

  // one classified byte
  typedef struct packed {
    logic       digit;
    logic [3:0] dval;
    logic       dot;
    logic       comma;
    logic       star;
    logic       is_p;
    logic       is_r;
    logic       is_c;
    logic [2:0] lc_lever;
    logic [2:0] lc_rpm;
    logic [2:0] lc_pitch;
    logic [2:0] lc_loc;
    logic       last;
  } cls_t;

  typedef struct packed {
    logic [13:0] lever_position;
    logic        lever_status;
    logic [13:0] rpm_demand;
    logic [1:0]  rpm_mode;
    logic [13:0] pitch_demand;
    logic [1:0]  pitch_mode;
    logic [2:0]  location;
    logic [7:0]  shaft_count;
  } held_t;

  typedef struct packed {
    logic [3:0] status;
    held_t      held;
  } res_t;

endpackage

`default_nettype wire

[rtl/nprc_fifo.sv]
// Small register-based queue, used between the parser stages and on the result side.
// Standalone; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nprc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);

endmodule

`default_nettype wire

[rtl/nprc_front.sv]
// Front end: takes input beats and classifies each character for the back end.
// Depends on nprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nprc_front
  import nprc_pkg::*;
(
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  input  logic       push,
  input  logic       full,
  output logic       wr_en,
  output cls_t       entry
);

  always_comb begin
    entry       = '0;
    entry.digit = byte_in inside {[CH_0:CH_9]};
    entry.dval  = byte_in[3:0];
    entry.dot   = (byte_in == CH_DOT);
    entry.comma = (byte_in == CH_COMMA);
    entry.star  = (byte_in == CH_STAR);
    entry.is_p  = (byte_in == CH_P);
    entry.is_r  = (byte_in == CH_R);
    entry.is_c  = (byte_in == CH_C);
    entry.last  = last_byte;

    case (byte_in)
      CH_A:    entry.lc_lever = 3'd0;
      CH_V:    entry.lc_lever = 3'd1;
      default: entry.lc_lever = LETTER_BAD;
    endcase

    case (byte_in)
      CH_P:    entry.lc_rpm = 3'd0;
      CH_R:    entry.lc_rpm = 3'd1;
      CH_V:    entry.lc_rpm = 3'd2;
      default: entry.lc_rpm = LETTER_BAD;
    endcase

    case (byte_in)
      CH_P:    entry.lc_pitch = 3'd0;
      CH_D:    entry.lc_pitch = 3'd1;
      CH_V:    entry.lc_pitch = 3'd2;
      default: entry.lc_pitch = LETTER_BAD;
    endcase

    case (byte_in)
      CH_B:    entry.lc_loc = 3'd0;
      CH_P:    entry.lc_loc = 3'd1;
      CH_S:    entry.lc_loc = 3'd2;
      CH_C:    entry.lc_loc = 3'd3;
      CH_E:    entry.lc_loc = 3'd4;
      CH_W:    entry.lc_loc = 3'd5;
      default: entry.lc_loc = LETTER_BAD;
    endcase
  end

  assign wr_en = push & ~full;

endmodule

`default_nettype wire

[rtl/nprc_back.sv]
// Back end: field parser state, held field registers and result generation.
// Depends on nprc_pkg; fed from the classified-byte queue.
`timescale 1ns / 1ps
`default_nettype none

module nprc_back
  import nprc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cls_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  logic [3:0]  fld_idx_r, fld_idx_nxt;
  logic [2:0]  fld_len_r, fld_len_nxt;
  logic        hdr_match_r, hdr_match_nxt;
  logic [13:0] acc_r, acc_nxt;
  logic        bad_r, bad_nxt;
  logic        dot_r, dot_nxt;
  logic        ok_r, ok_nxt;
  logic [2:0]  lc_r, lc_nxt;
  logic [3:0]  err_r, err_nxt;
  logic        done_r, done_nxt;
  held_t       held_r, held_nxt;
  logic [17:0] acc_ext;

  function automatic logic is_num(input logic [3:0] f);
    return (f == FLD_LEVER_POS) || (f == FLD_RPM) || (f == FLD_PITCH) || (f == FLD_SHAFT);
  endfunction

  function automatic logic tok_pass(input logic [3:0] f, input logic [2:0] len,
                                    input logic hm, input logic bad, input logic ok,
                                    input logic [2:0] lc);
    logic p;
    if (f == FLD_HDR) begin
      p = (len == HDR_LEN) && hm;
    end else if (is_num(f)) begin
      p = (len != 3'd0) && !bad && ok;
    end else begin
      p = (len == 3'd1) && (lc != LETTER_BAD);
    end
    return p;
  endfunction

  function automatic held_t hold_write(input held_t h, input logic [3:0] f,
                                       input logic [13:0] acc, input logic [2:0] lc);
    held_t n;
    n = h;
    case (f)
      FLD_LEVER_POS:  n.lever_position = acc;
      FLD_LEVER_ST:   n.lever_status   = lc[0];
      FLD_RPM:        n.rpm_demand     = acc;
      FLD_RPM_MODE:   n.rpm_mode       = lc[1:0];
      FLD_PITCH:      n.pitch_demand   = acc;
      FLD_PITCH_MODE: n.pitch_mode     = lc[1:0];
      FLD_LOC:        n.location       = lc;
      FLD_SHAFT:      n.shaft_count    = (acc > 14'(SHAFT_MAX)) ? SHAFT_MAX : acc[7:0];
      default:        n = h;
    endcase
    return n;
  endfunction

  always_comb begin
    fld_idx_nxt   = fld_idx_r;
    fld_len_nxt   = fld_len_r;
    hdr_match_nxt = hdr_match_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    dot_nxt       = dot_r;
    ok_nxt        = ok_r;
    lc_nxt        = lc_r;
    err_nxt       = err_r;
    done_nxt      = done_r;
    held_nxt      = held_r;
    acc_ext       = '0;

    cmd_pop  = cmd_valid && (!cmd.last || !res_full);
    res_push = cmd_pop && cmd.last;

    if (err_r == ST_OK && !done_r) begin
      if (cmd.comma && fld_idx_r <= FLD_LOC) begin
        if (tok_pass(fld_idx_r, fld_len_r, hdr_match_r, bad_r, ok_r, lc_r)) begin
          held_nxt      = hold_write(held_r, fld_idx_r, acc_r, lc_r);
          fld_idx_nxt   = fld_idx_r + 4'd1;
          fld_len_nxt   = '0;
          hdr_match_nxt = 1'b1;
          acc_nxt       = '0;
          bad_nxt       = 1'b0;
          dot_nxt       = 1'b0;
          ok_nxt        = 1'b0;
          lc_nxt        = '0;
        end else begin
          err_nxt = fld_idx_r + 4'd1;
        end
      end else if (cmd.star && fld_idx_r == FLD_SHAFT) begin
        if (tok_pass(fld_idx_r, fld_len_r, hdr_match_r, bad_r, ok_r, lc_r)) begin
          held_nxt = hold_write(held_r, fld_idx_r, acc_r, lc_r);
          done_nxt = 1'b1;
        end else begin
          err_nxt = FLD_SHAFT + 4'd1;
        end
      end else begin
        if (fld_idx_r == FLD_HDR) begin
          if ((fld_len_r == 3'd3 && !cmd.is_p) || (fld_len_r == 3'd4 && !cmd.is_r) ||
              (fld_len_r == 3'd5 && !cmd.is_c)) begin
            hdr_match_nxt = 1'b0;
          end
        end else if (is_num(fld_idx_r)) begin
          if (cmd.digit) begin
            if (!dot_r) begin
              acc_ext = 18'(acc_r) * 18'd10 + 18'(cmd.dval);
              acc_nxt = (acc_ext > 18'(NUM_MAX)) ? NUM_MAX : acc_ext[13:0];
            end
            // a leading dot is allowed before the first digit, except in the shaft field
            if (fld_len_r == 3'd0 ||
                (fld_idx_r != FLD_SHAFT && fld_len_r == 3'd1 && dot_r)) begin
              ok_nxt = 1'b1;
            end
          end else if (cmd.dot) begin
            dot_nxt = 1'b1;
          end else begin
            bad_nxt = 1'b1;
          end
        end else if (fld_len_r == 3'd0) begin
          case (fld_idx_r)
            FLD_LEVER_ST:   lc_nxt = cmd.lc_lever;
            FLD_RPM_MODE:   lc_nxt = cmd.lc_rpm;
            FLD_PITCH_MODE: lc_nxt = cmd.lc_pitch;
            default:        lc_nxt = cmd.lc_loc;
          endcase
        end
        if (fld_len_r != LEN_MAX) begin
          fld_len_nxt = fld_len_r + 3'd1;
        end
      end
    end

    if (cmd.last) begin
      // end of sentence closes the open token
      if (err_nxt == ST_OK && !done_nxt) begin
        if (tok_pass(fld_idx_nxt, fld_len_nxt, hdr_match_nxt, bad_nxt, ok_nxt, lc_nxt)) begin
          held_nxt = hold_write(held_nxt, fld_idx_nxt, acc_nxt, lc_nxt);
          if (fld_idx_nxt < FLD_SHAFT) begin
            err_nxt = fld_idx_nxt + 4'd2;
          end
        end else begin
          err_nxt = fld_idx_nxt + 4'd1;
        end
      end
    end

    res.status = err_nxt;
    res.held   = held_nxt;

    if (cmd.last) begin
      fld_idx_nxt   = FLD_HDR;
      fld_len_nxt   = '0;
      hdr_match_nxt = 1'b1;
      acc_nxt       = '0;
      bad_nxt       = 1'b0;
      dot_nxt       = 1'b0;
      ok_nxt        = 1'b0;
      lc_nxt        = '0;
      err_nxt       = ST_OK;
      done_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_idx_r   <= FLD_HDR;
      fld_len_r   <= '0;
      hdr_match_r <= 1'b1;
      acc_r       <= '0;
      bad_r       <= 1'b0;
      dot_r       <= 1'b0;
      ok_r        <= 1'b0;
      lc_r        <= '0;
      err_r       <= ST_OK;
      done_r      <= 1'b0;
      held_r      <= '0;
    end else if (cmd_pop) begin
      fld_idx_r   <= fld_idx_nxt;
      fld_len_r   <= fld_len_nxt;
      hdr_match_r <= hdr_match_nxt;
      acc_r       <= acc_nxt;
      bad_r       <= bad_nxt;
      dot_r       <= dot_nxt;
      ok_r        <= ok_nxt;
      lc_r        <= lc_nxt;
      err_r       <= err_nxt;
      done_r      <= done_nxt;
      held_r      <= held_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/nmea_prc_sentence_parser.sv]
// Channel  | Direction | Handshake          | Beat
// in_      | in        | in_push / in_full  | one sentence character, last-byte mark
// out_     | out       | out_pop / out_empty| status and held fields, one per sentence
//
// One character per cycle while in_full is low; the back end takes each beat from the queue.
// An accepted beat is written into the classified-byte queue and popped by the back end from
// there; a final byte's result is registered in the result queue as that byte is popped.
// A result only stalls the back end when the result queue is full and a last byte waits.
// Synchronous active-low reset empties both queues and clears all held fields.
// Top level: front end, classified-byte queue, back end, result queue. Depends on nprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmea_prc_sentence_parser
  import nprc_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = 4,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [3:0]  out_status,
  output logic [13:0] out_lever_position,
  output logic        out_lever_status,
  output logic [13:0] out_rpm_demand,
  output logic [1:0]  out_rpm_mode,
  output logic [13:0] out_pitch_demand,
  output logic [1:0]  out_pitch_mode,
  output logic [2:0]  out_location,
  output logic [7:0]  out_shaft_count
);

  logic cmd_wr;
  cls_t cmd_wr_data;
  cls_t cmd_rd_data;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  res_t res_wr_data;
  res_t res_rd_data;
  logic res_full;

  nprc_front u_front (
    .byte_in   (in_byte_in),
    .last_byte (in_last_byte),
    .push      (in_push),
    .full      (in_full),
    .wr_en     (cmd_wr),
    .entry     (cmd_wr_data)
  );

  nprc_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_wr_data),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_data),
    .full    (in_full),
    .empty   (cmd_empty)
  );

  nprc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (~cmd_empty),
    .cmd       (cmd_rd_data),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_wr_data)
  );

  nprc_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_wr_data),
    .rd_en   (out_pop & ~out_empty),
    .rd_data (res_rd_data),
    .full    (res_full),
    .empty   (out_empty)
  );

  assign out_status         = res_rd_data.status;
  assign out_lever_position = res_rd_data.held.lever_position;
  assign out_lever_status   = res_rd_data.held.lever_status;
  assign out_rpm_demand     = res_rd_data.held.rpm_demand;
  assign out_rpm_mode       = res_rd_data.held.rpm_mode;
  assign out_pitch_demand   = res_rd_data.held.pitch_demand;
  assign out_pitch_mode     = res_rd_data.held.pitch_mode;
  assign out_location       = res_rd_data.held.location;
  assign out_shaft_count    = res_rd_data.held.shaft_count;

`ifndef SYNTHESIS
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_pop_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd_rd_data.last) |-> res_push)
    else $error("last beat consumed without a result");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_status <= 4'd9))
    else $error("status out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");
`endif

endmodule

`default_nettype wire
